// ===== src/bheq_pkg.sv =====
// Shared types and constants for the barrier hit event qualifier.
`default_nettype none

package bheq_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DELTA_W    = 24;
  localparam int unsigned DIST_CFG_W = 16;
  localparam int unsigned REPORT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] RESET_DELAY_DEFAULT = 32'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_DELAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WAIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DISTANCE = 2'd2;

  localparam logic MODE_HIT   = 1'b0;
  localparam logic MODE_LEAVE = 1'b1;

  localparam logic [1:0] BARRIER_HORIZONTAL = 2'd0;
  localparam logic [1:0] BARRIER_VERTICAL   = 2'd1;

  localparam logic REPORT_HIT   = 1'b0;
  localparam logic REPORT_LEAVE = 1'b1;

  // Partial products issued to the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    MUL_X_LL,
    MUL_X_LH,
    MUL_X_HH,
    MUL_Y_LL,
    MUL_Y_LH,
    MUL_Y_HH,
    MUL_D_D
  } mul_sel_t;

  typedef struct packed {
    logic                      mode;
    logic [1:0]                barrier;
    logic [TIME_W-1:0]         event_time;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic                report_kind;
    logic [REPORT_W-1:0] travel_distance;
    logic [TIME_W-1:0]   elapsed_time;
  } out_item_t;

  typedef struct packed {
    logic     load;
    logic     update;
    logic     mag;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     set_wfl;
    logic     root_start;
    logic     out_load;
    logic     clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_leave;
    logic still_hit;
    logic triggers;
    logic hit_report;
    logic root_busy;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/bheq_stream_if.sv =====
// Valid/ready stream interface carrying one payload item per transfer.
`default_nettype none

interface bheq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/bheq_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module bheq_sqrt #(
  parameter int unsigned ROOT_W = 41
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       busy,
  output logic [ROOT_W-1:0]          root
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [CNT_W-1:0]    cnt_r;
  logic [2*ROOT_W-1:0] rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                take;
  logic [REM_W-1:0]    rem_nxt;
  logic [ROOT_W-1:0]   root_nxt;

  // The remainder never exceeds twice the partial root, so its top two bits
  // are clear before each shift.
  always_comb begin
    rem_sh   = {rem_r[ROOT_W-1:0], rad_r[2*ROOT_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    take     = (rem_sh >= trial);
    rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(ROOT_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign root = root_r;

endmodule

`default_nettype wire

// ===== src/bheq_dp.sv =====
// Datapath: configuration, event state, sums, squared length and result register.
`default_nettype none

module bheq_dp #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned SUM_WIDTH     = 40
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bheq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bheq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire bheq_pkg::in_item_t                in_payload,
  input  wire bheq_pkg::ctrl_cmd_t               cmd,
  output bheq_pkg::dp_status_t                   status,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bheq_pkg::out_item_t                    out_payload
);

  localparam int unsigned HALF_W = (SUM_WIDTH + 1) / 2;
  localparam int unsigned PROD_W = 2 * HALF_W;
  localparam int unsigned ACC_W  = 2 * SUM_WIDTH;
  localparam int unsigned ROOT_W = SUM_WIDTH + 1;
  localparam int unsigned EXT_W  = SUM_WIDTH + 1;
  localparam int unsigned DW     = bheq_pkg::DELTA_W;
  localparam int unsigned TW     = bheq_pkg::TIME_W;
  localparam int unsigned RW     = bheq_pkg::REPORT_W;

  // Configuration.
  logic [TW-1:0]                     reset_delay_r;
  logic [TW-1:0]                     hold_time_r;
  logic [bheq_pkg::DIST_CFG_W-1:0]   travel_limit_r;

  // Event state.
  bheq_pkg::in_item_t                item_r;
  logic [TW-1:0]                     timer_origin_r;
  logic [TW-1:0]                     prev_hit_r;
  logic                              hhit_r;
  logic                              vhit_r;
  logic                              wfl_r;
  logic [SUM_WIDTH-1:0]              sum_x_r;
  logic [SUM_WIDTH-1:0]              sum_y_r;

  // Squared length.
  logic [SUM_WIDTH-1:0]              mag_x_r;
  logic [SUM_WIDTH-1:0]              mag_y_r;
  logic [PROD_W-1:0]                 prod_r;
  logic                              prod_vld_r;
  bheq_pkg::mul_sel_t                prod_sel_r;
  logic [ACC_W-1:0]                  acc_r;
  logic [ACC_W-1:0]                  lim_r;

  // Result register.
  logic                              out_valid_r;
  bheq_pkg::out_item_t               out_item_r;

  logic [PROD_W-1:0]                 mag_x_pad;
  logic [PROD_W-1:0]                 mag_y_pad;
  logic [HALF_W-1:0]                 mul_a;
  logic [HALF_W-1:0]                 mul_b;
  logic [ACC_W-1:0]                  term;
  logic [TW-1:0]                     gap;
  logic [TW-1:0]                     since;
  logic                              triggers;
  logic                              below;
  logic                              hhit_leave;
  logic                              vhit_leave;
  logic                              root_busy;
  logic [ROOT_W-1:0]                 root;
  logic [ROOT_W:0]                   rnd;
  logic [ROOT_W:0]                   rnd_sh;
  logic [RW-1:0]                     dist_sat;

  function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                   input logic [DW-1:0]        d);
    logic [EXT_W-1:0] r;
    r = {s[SUM_WIDTH-1], s} + {{(EXT_W-DW){d[DW-1]}}, d};
    if (r[EXT_W-1] != r[EXT_W-2]) begin
      sat_add = r[EXT_W-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sat_add = r[SUM_WIDTH-1:0];
    end
  endfunction

  function automatic logic [SUM_WIDTH-1:0] magnitude(input logic [SUM_WIDTH-1:0] v);
    magnitude = v[SUM_WIDTH-1] ? (~v + {{(SUM_WIDTH-1){1'b0}}, 1'b1}) : v;
  endfunction

  always_comb begin
    mag_x_pad = PROD_W'(mag_x_r);
    mag_y_pad = PROD_W'(mag_y_r);
    case (cmd.mul_sel)
      bheq_pkg::MUL_X_LL: begin
        mul_a = mag_x_pad[HALF_W-1:0];
        mul_b = mag_x_pad[HALF_W-1:0];
      end
      bheq_pkg::MUL_X_LH: begin
        mul_a = mag_x_pad[HALF_W-1:0];
        mul_b = mag_x_pad[PROD_W-1:HALF_W];
      end
      bheq_pkg::MUL_X_HH: begin
        mul_a = mag_x_pad[PROD_W-1:HALF_W];
        mul_b = mag_x_pad[PROD_W-1:HALF_W];
      end
      bheq_pkg::MUL_Y_LL: begin
        mul_a = mag_y_pad[HALF_W-1:0];
        mul_b = mag_y_pad[HALF_W-1:0];
      end
      bheq_pkg::MUL_Y_LH: begin
        mul_a = mag_y_pad[HALF_W-1:0];
        mul_b = mag_y_pad[PROD_W-1:HALF_W];
      end
      bheq_pkg::MUL_Y_HH: begin
        mul_a = mag_y_pad[PROD_W-1:HALF_W];
        mul_b = mag_y_pad[PROD_W-1:HALF_W];
      end
      bheq_pkg::MUL_D_D: begin
        mul_a = HALF_W'(travel_limit_r);
        mul_b = HALF_W'(travel_limit_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The cross term appears twice in the square, hence the extra bit of shift.
  always_comb begin
    case (prod_sel_r)
      bheq_pkg::MUL_X_LL, bheq_pkg::MUL_Y_LL: term = ACC_W'(prod_r);
      bheq_pkg::MUL_X_LH, bheq_pkg::MUL_Y_LH: term = ACC_W'(prod_r) << (HALF_W + 1);
      bheq_pkg::MUL_X_HH, bheq_pkg::MUL_Y_HH: term = ACC_W'(prod_r) << (2 * HALF_W);
      default:                                term = '0;
    endcase
  end

  always_comb begin
    gap        = item_r.event_time - prev_hit_r;
    since      = item_r.event_time - timer_origin_r;
    triggers   = (hold_time_r != '0) || (travel_limit_r != '0);
    below      = (lim_r > acc_r);
    hhit_leave = (item_r.barrier == bheq_pkg::BARRIER_HORIZONTAL) ? 1'b0 : hhit_r;
    vhit_leave = (item_r.barrier == bheq_pkg::BARRIER_VERTICAL) ? 1'b0 : vhit_r;
    rnd        = {1'b0, root} + ((ROOT_W + 1)'(1) << FRACTION_BITS);
    rnd_sh     = rnd >> (FRACTION_BITS + 1);
    dist_sat   = (|rnd_sh[ROOT_W:RW]) ? {RW{1'b1}} : rnd_sh[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_delay_r  <= bheq_pkg::RESET_DELAY_DEFAULT;
      hold_time_r    <= '0;
      travel_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bheq_pkg::CFG_RESET_DELAY:      reset_delay_r  <= cfg_data;
        bheq_pkg::CFG_TRIGGER_WAIT:     hold_time_r    <= cfg_data;
        bheq_pkg::CFG_TRIGGER_DISTANCE: travel_limit_r <= cfg_data[bheq_pkg::DIST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_origin_r <= '0;
      prev_hit_r     <= '0;
      hhit_r         <= 1'b0;
      vhit_r         <= 1'b0;
      wfl_r          <= 1'b0;
      sum_x_r        <= '0;
      sum_y_r        <= '0;
      prod_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_go;
      if (cmd.update) begin
        if (item_r.mode == bheq_pkg::MODE_HIT) begin
          if (item_r.barrier == bheq_pkg::BARRIER_HORIZONTAL) hhit_r <= 1'b1;
          if (item_r.barrier == bheq_pkg::BARRIER_VERTICAL)   vhit_r <= 1'b1;
          prev_hit_r <= item_r.event_time;
          if (gap > reset_delay_r) timer_origin_r <= item_r.event_time;
          sum_x_r <= sat_add(sum_x_r, item_r.delta_x);
          sum_y_r <= sat_add(sum_y_r, item_r.delta_y);
        end else begin
          hhit_r <= hhit_leave;
          vhit_r <= vhit_leave;
        end
      end
      if (cmd.set_wfl && triggers) wfl_r <= 1'b1;
      if (cmd.clear) begin
        wfl_r      <= 1'b0;
        sum_x_r    <= '0;
        sum_y_r    <= '0;
        prev_hit_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_payload;
    if (cmd.mag) begin
      mag_x_r <= magnitude(sum_x_r);
      mag_y_r <= magnitude(sum_y_r);
      acc_r   <= '0;
    end else if (prod_vld_r) begin
      if (prod_sel_r == bheq_pkg::MUL_D_D) begin
        lim_r <= ACC_W'(prod_r) << (2 * FRACTION_BITS);
      end else begin
        acc_r <= acc_r + term;
      end
    end
    if (cmd.mul_go) begin
      prod_r     <= mul_a * mul_b;
      prod_sel_r <= cmd.mul_sel;
    end
    if (cmd.out_load) begin
      out_item_r.report_kind     <= (item_r.mode == bheq_pkg::MODE_LEAVE) ?
                                    bheq_pkg::REPORT_LEAVE : bheq_pkg::REPORT_HIT;
      out_item_r.travel_distance <= dist_sat;
      out_item_r.elapsed_time    <= since;
    end
  end

  bheq_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand ({acc_r, 2'b00}),
    .busy     (root_busy),
    .root     (root)
  );

  always_comb begin
    status.is_leave   = (item_r.mode == bheq_pkg::MODE_LEAVE);
    status.still_hit  = hhit_leave || vhit_leave;
    status.triggers   = triggers;
    status.hit_report = !wfl_r && !(since < hold_time_r) && !below;
    status.root_busy  = root_busy;
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

endmodule

`default_nettype wire

// ===== src/bheq_ctrl.sv =====
// Controller state machine sequencing each event through the datapath.
`default_nettype none

module bheq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bheq_pkg::dp_status_t status,
  output bheq_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MAG,
    S_MUL,
    S_DRAIN,
    S_DECIDE,
    S_ROOT_START,
    S_ROOT,
    S_OUT,
    S_CLEAR
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  bheq_pkg::mul_sel_t mul_sel_r;
  bheq_pkg::mul_sel_t mul_sel_nxt;

  always_comb begin
    state_nxt   = state_r;
    mul_sel_nxt = mul_sel_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (!status.is_leave) begin
          state_nxt = S_MAG;
        end else if (status.still_hit) begin
          state_nxt = S_IDLE;
        end else if (status.triggers) begin
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag     = 1'b1;
        mul_sel_nxt = bheq_pkg::MUL_X_LL;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mul_sel_r;
        if (mul_sel_r == bheq_pkg::MUL_D_D) begin
          state_nxt = S_DRAIN;
        end else begin
          mul_sel_nxt = bheq_pkg::mul_sel_t'(mul_sel_r + 3'd1);
        end
      end
      S_DRAIN: begin
        // The last product is already in its register and is folded into the limit during this cycle.
        state_nxt = status.is_leave ? S_ROOT_START : S_DECIDE;
      end
      S_DECIDE: begin
        if (status.hit_report) begin
          cmd.set_wfl = 1'b1;
          state_nxt   = S_ROOT_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROOT_START: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (!status.root_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.is_leave ? S_CLEAR : S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mul_sel_r <= bheq_pkg::MUL_X_LL;
    end else begin
      state_r   <= state_nxt;
      mul_sel_r <= mul_sel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ===== src/barrier_hit_event_qualifier.sv =====
// Top level of the barrier hit event qualifier: controller, datapath and checks.
//
// Takes one barrier hit or leave event at a time on in_ch and gives at most one report on
// out_ch. A hit event that produces a report holds off the next input transfer, chiefly
// while the square root unit runs; that unit resolves one bit of the distance per cycle. A
// hit with no report spends most of its time on the seven products through the single
// multiplier: six partial products of the squared length and the square of the limit.
// A leave that finds a barrier still hit returns to idle after its update, one that clears
// silently goes through the clear step, and a leave report takes as long as a hit report.
// The report sits in an output register, so the next event is taken while it waits; a
// further report stalls only if that register is still full. Configuration writes on
// cfg_we/cfg_index/cfg_data take effect at once and must be made while no event is in progress.
`default_nettype none

module barrier_hit_event_qualifier #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned SUM_WIDTH     = 40
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bheq_stream_if.sink                           in_ch,
  bheq_stream_if.source                         out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [bheq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bheq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bheq_pkg::ctrl_cmd_t  cmd;
  bheq_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  bheq_pkg::out_item_t  out_payload;

  bheq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bheq_dp #(
    .FRACTION_BITS (FRACTION_BITS),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_payload  (in_ch.payload),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_payload)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_payload;

`ifndef ASSERT_OFF
  // A result is only written into the output register once it is free.
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken result");

  // A leave is reported only when no trigger is configured.
  a_leave_report_no_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && status.is_leave) |-> !status.triggers)
    else $error("leave report with a trigger set");

  // Starting the square root must make it busy on the following cycle.
  a_root_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_start |=> status.root_busy)
    else $error("square root did not start");

  // An input transfer is never taken while the square root is running.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !status.root_busy)
    else $error("input taken during square root");
`endif

endmodule

`default_nettype wire
